@@ rtl/crs_pkg.sv @@
package crs_pkg;

  localparam int SRC_DIM_MAX_DEF = 256;
  localparam int OUT_DIM_MAX_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int FRAC_W   = 8;
  localparam int SAMPLE_W = 24;
  localparam int HEIGHT_W = 16;

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_SRC_SIZE = 2'd0,
    REG_OUT_SIZE = 2'd1,
    REG_BIAS_U   = 2'd2,
    REG_BIAS_V   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]         src_size;
    logic [8:0]         out_size;
    logic signed [17:0] bias_u;
    logic signed [17:0] bias_v;
  } cfg_t;

endpackage

@@ rtl/clipmap_bilinear_resample_unit.sv @@
// Bilinear resampler over a stored square height map.
// Input channel (in_valid/in_ready): an item either writes one Q8 source
// sample at (in_row, in_col) or asks for one output pixel of the centred
// window at (in_row, in_col). Writes give no result; every compute item gives
// exactly one result on the out channel (out_height, out_inside_res), in order.
// Configuration (src_size, out_size, bias_u, bias_v) sits on the APB port at
// byte addresses 0, 4, 8 and 12 and must be changed only while the block is
// idle, a rule for the user that the block itself does not enforce.
// Throughput is one item per cycle while out_ready is high. A compute item
// passes through the four-entry queue, the registered read of the four parity
// banks with the vertical blend behind it, and the horizontal blend into the
// output register. A write reaches its bank when it leaves the queue and is
// seen by any compute item taken after it.
// Reset returns the registers to 256, 256, 0 and 0 and empties the queue and
// pipeline; the map itself is not cleared and holds nothing defined until
// written. When out_ready is low with a result shown, the pipeline holds its
// place, the queue fills and in_ready falls once its four entries are taken.
module clipmap_bilinear_resample_unit #(
  parameter int SRC_DIM_MAX = crs_pkg::SRC_DIM_MAX_DEF,
  parameter int OUT_DIM_MAX = crs_pkg::OUT_DIM_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  input  logic [23:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_height,
  output logic        out_inside_res
);
  import crs_pkg::*;

  localparam int IW = $clog2(SRC_DIM_MAX);
  localparam int QW = 2 + 2 * IW + 2 * FRAC_W + SAMPLE_W;

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_size <= 9'd256;
      cfg_r.out_size <= 9'd256;
      cfg_r.bias_u   <= '0;
      cfg_r.bias_v   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SRC_SIZE: cfg_r.src_size <= pwdata[8:0];
        REG_OUT_SIZE: cfg_r.out_size <= pwdata[8:0];
        REG_BIAS_U:   cfg_r.bias_u   <= $signed(pwdata[17:0]);
        REG_BIAS_V:   cfg_r.bias_v   <= $signed(pwdata[17:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SRC_SIZE: prdata = {23'd0, cfg_r.src_size};
      REG_OUT_SIZE: prdata = {23'd0, cfg_r.out_size};
      REG_BIAS_U:   prdata = {{14{cfg_r.bias_u[17]}}, cfg_r.bias_u};
      REG_BIAS_V:   prdata = {{14{cfg_r.bias_v[17]}}, cfg_r.bias_v};
    endcase
  end

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_din, q_dout;

  crs_front #(
    .SRC_DIM_MAX (SRC_DIM_MAX),
    .OUT_DIM_MAX (OUT_DIM_MAX),
    .QW          (QW)
  ) u_front (
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  crs_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  crs_back #(
    .SRC_DIM_MAX (SRC_DIM_MAX),
    .QW          (QW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_height     (out_height),
    .out_inside_res (out_inside_res)
  );

endmodule

@@ rtl/crs_ram.sv @@
module crs_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/crs_queue.sv @@
module crs_queue #(
  parameter int W     = 60,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy above its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into a full queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push && cnt_r == CW'(1) |=> empty)
    else $error("queue not empty after its last item left");

endmodule

@@ rtl/crs_front.sv @@
module crs_front #(
  parameter int SRC_DIM_MAX = 256,
  parameter int OUT_DIM_MAX = 256,
  parameter int QW          = 58
) (
  input  crs_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  input  logic [7:0]     in_row,
  input  logic [7:0]     in_col,
  input  logic [23:0]    in_sample,
  input  logic           q_full,
  output logic           q_push,
  output logic [QW-1:0]  q_din
);
  import crs_pkg::*;

  localparam int IW = $clog2(SRC_DIM_MAX);
  localparam int MA = (IW + 8 > 17) ? IW + 8 : 17;
  localparam int MB = ($clog2(OUT_DIM_MAX) + 8 > MA) ? $clog2(OUT_DIM_MAX) + 8 : MA;
  localparam int PW = MB + 3;

  logic signed [PW-1:0] src_ext, out_ext, ss_w, os_w;
  logic signed [PW-1:0] centre, limit, u_pos, v_pos;
  logic                 hit;
  logic [IW+7:0]        row_x, col_x;
  logic                 wr_ok, is_cmp;

  assign src_ext = $signed({{(PW-9){1'b0}}, cfg.src_size});
  assign out_ext = $signed({{(PW-9){1'b0}}, cfg.out_size});
  assign ss_w    = (src_ext > PW'(SRC_DIM_MAX)) ? PW'(SRC_DIM_MAX) : src_ext;
  assign os_w    = (out_ext > PW'(OUT_DIM_MAX)) ? PW'(OUT_DIM_MAX) : out_ext;

  // Half-pixel centring: (n-1)/2 in Q8 is (n-1) shifted by seven.
  assign centre = ((ss_w - PW'(1)) <<< 7) - ((os_w - PW'(1)) <<< 7);
  assign limit  = (ss_w - PW'(1)) <<< 8;

  assign u_pos = $signed({{(PW-16){1'b0}}, in_col, 8'h00}) + PW'(cfg.bias_u) + centre;
  assign v_pos = $signed({{(PW-16){1'b0}}, in_row, 8'h00}) + PW'(cfg.bias_v) + centre;

  assign hit = !u_pos[PW-1] && (u_pos < limit) && !v_pos[PW-1] && (v_pos < limit);

  assign row_x  = {{IW{1'b0}}, in_row};
  assign col_x  = {{IW{1'b0}}, in_col};
  assign wr_ok  = (row_x < (IW+8)'(SRC_DIM_MAX)) && (col_x < (IW+8)'(SRC_DIM_MAX));
  assign is_cmp = (action_t'(in_action) == ACT_COMPUTE);

  assign in_ready = !q_full;
  // A write that falls outside the map is taken and dropped here.
  assign q_push   = in_valid && !q_full && (is_cmp || wr_ok);

  always_comb begin
    if (is_cmp) begin
      q_din = {1'b1, hit, v_pos[IW+7:8], u_pos[IW+7:8], u_pos[7:0], v_pos[7:0],
               {SAMPLE_W{1'b0}}};
    end else begin
      q_din = {1'b0, 1'b0, row_x[IW-1:0], col_x[IW-1:0], {FRAC_W{1'b0}}, {FRAC_W{1'b0}},
               in_sample};
    end
  end

endmodule

@@ rtl/crs_back.sv @@
module crs_back #(
  parameter int SRC_DIM_MAX = 256,
  parameter int QW          = 58
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [QW-1:0] q_dout,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_height,
  output logic          out_inside_res
);
  import crs_pkg::*;

  localparam int IW    = $clog2(SRC_DIM_MAX);
  localparam int HW    = (IW > 1) ? IW - 1 : 1;
  localparam int BANKD = 1 << (2 * HW);

  logic                is_cmp, hit;
  logic [IW-1:0]       e_r, e_c;
  logic [FRAC_W-1:0]   e_fu, e_fv;
  logic [SAMPLE_W-1:0] e_data;

  assign {is_cmp, hit, e_r, e_c, e_fu, e_fv, e_data} = q_dout;

  logic advance;
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && !q_empty;

  // Row and column halves for the even/odd banks; the bank of parity zero
  // takes the next row (or column) when the base index is odd.
  logic [IW:0] r_ext, c_ext, rp_ext, cp_ext;
  logic [IW-1:0] r_half, c_half, rp_half, cp_half;

  assign r_ext   = {1'b0, e_r};
  assign c_ext   = {1'b0, e_c};
  assign rp_ext  = r_ext + 1'b1;
  assign cp_ext  = c_ext + 1'b1;
  assign r_half  = r_ext[IW:1];
  assign c_half  = c_ext[IW:1];
  assign rp_half = rp_ext[IW:1];
  assign cp_half = cp_ext[IW:1];

  logic                re;
  logic [SAMPLE_W-1:0] bank_q [2][2];

  assign re = q_pop && is_cmp && hit;

  for (genvar pr = 0; pr < 2; pr++) begin : g_row
    for (genvar pc = 0; pc < 2; pc++) begin : g_col
      logic          we;
      logic [IW-1:0] rd_rh, rd_ch;

      assign we    = q_pop && !is_cmp && (e_r[0] == 1'(pr)) && (e_c[0] == 1'(pc));
      assign rd_rh = ((pr == 0) && e_r[0]) ? rp_half : r_half;
      assign rd_ch = ((pc == 0) && e_c[0]) ? cp_half : c_half;

      crs_ram #(
        .W     (SAMPLE_W),
        .DEPTH (BANKD)
      ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr ({r_half[HW-1:0], c_half[HW-1:0]}),
        .wdata (e_data),
        .re    (re),
        .raddr ({rd_rh[HW-1:0], rd_ch[HW-1:0]}),
        .rdata (bank_q[pr][pc])
      );
    end
  end

  // Stage one: RAM data returns; blend vertically.
  logic              s1_v_r, s1_in_r, s1_p0_r, s1_q0_r;
  logic [FRAC_W-1:0] s1_fu_r, s1_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= q_pop && is_cmp;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_in_r <= hit;
      s1_p0_r <= e_r[0];
      s1_q0_r <= e_c[0];
      s1_fu_r <= e_fu;
      s1_fv_r <= e_fv;
    end
  end

  logic [SAMPLE_W-1:0] d1, d2, d3, d4;

  always_comb begin
    unique case ({s1_p0_r, s1_q0_r})
      2'b00: begin
        d1 = bank_q[0][0]; d2 = bank_q[0][1]; d3 = bank_q[1][0]; d4 = bank_q[1][1];
      end
      2'b01: begin
        d1 = bank_q[0][1]; d2 = bank_q[0][0]; d3 = bank_q[1][1]; d4 = bank_q[1][0];
      end
      2'b10: begin
        d1 = bank_q[1][0]; d2 = bank_q[1][1]; d3 = bank_q[0][0]; d4 = bank_q[0][1];
      end
      default: begin
        d1 = bank_q[1][1]; d2 = bank_q[1][0]; d3 = bank_q[0][1]; d4 = bank_q[0][0];
      end
    endcase
  end

  logic signed [24:0] vd_l, vd_r;
  logic signed [8:0]  fv_s, fu_s;
  logic signed [33:0] vp_l, vp_r, lsum, rsum;

  assign fv_s = $signed({1'b0, s1_fv_r});
  assign vd_l = $signed({1'b0, d3}) - $signed({1'b0, d1});
  assign vd_r = $signed({1'b0, d4}) - $signed({1'b0, d2});
  assign vp_l = 34'(vd_l) * 34'(fv_s);
  assign vp_r = 34'(vd_r) * 34'(fv_s);
  assign lsum = $signed({2'b00, d1, 8'h00}) + vp_l;
  assign rsum = $signed({2'b00, d2, 8'h00}) + vp_r;

  // Stage two: blend horizontally.
  logic              s2_v_r, s2_in_r;
  logic [FRAC_W-1:0] s2_fu_r;
  logic [31:0]       s2_left_r, s2_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      s2_in_r    <= s1_in_r;
      s2_fu_r    <= s1_fu_r;
      s2_left_r  <= lsum[31:0];
      s2_right_r <= rsum[31:0];
    end
  end

  logic signed [32:0] hd;
  logic signed [41:0] hp, acc;

  assign fu_s = $signed({1'b0, s2_fu_r});
  assign hd   = $signed({1'b0, s2_right_r}) - $signed({1'b0, s2_left_r});
  assign hp   = 42'(hd) * 42'(fu_s);
  assign acc  = $signed({2'b00, s2_left_r, 8'h00}) + hp;

  // Output register.
  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_height_r;
  logic                out_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_v_r) begin
      out_height_r <= s2_in_r ? acc[39:24] : '0;
      out_inside_r <= s2_in_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height     = out_height_r;
  assign out_inside_res = out_inside_r;

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crs_pkg::*;

  localparam int     MAP_DIM     = SRC_DIM_MAX_DEF;
  localparam int     WIN_DIM     = OUT_DIM_MAX_DEF;
  localparam int     PHASES      = 7;
  localparam int     PHASE_ITEMS = 105;
  localparam int     DRAIN_WAIT  = 8;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int     PHASE_IDLE [PHASES] = '{25, 40, 0, 15, 30, 50, 0};

  typedef struct packed {
    logic [15:0] height;
    logic        hit;
  } pixel_t;

  typedef struct packed {
    logic   typed;
    pixel_t px;
  } preset_t;

  typedef enum logic { STEP_ITEM, STEP_REG } step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    reg_idx_t    idx;
    action_t     act;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] data;
    logic        typed;
    pixel_t      px;
  } step_t;

  localparam pixel_t NO_PX = '0;

  // Directed part. Register settings start from reset (256, 256, 0, 0).
  localparam step_t PLAN [37] = '{
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'hFF_FFFF, 1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd1,   32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd1,   8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd1,   8'd1,   32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'hFFFF, 1'b1}},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd255, 8'd255, 32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd255, 8'd0,   32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd254, 8'd254, 32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd254, 8'd255, 32'hFF_FFFF, 1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd255, 8'd254, 32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd255, 8'd255, 32'hFF_FFFF, 1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd254, 8'd254, 32'h0, 1'b1, '{16'd0, 1'b1}},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'h100,     1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'd1, 1'b1}},
    '{STEP_REG,  REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd511,     1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'd1, 1'b1}},
    '{STEP_REG,  REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd1,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_REG,  REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd128, 8'd128, 32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_REG,  REG_SRC_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd256,     1'b0, NO_PX},
    '{STEP_REG,  REG_BIAS_U,   ACT_WRITE,   8'd0,   8'd0,   32'h80,      1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd254, 8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_REG,  REG_BIAS_U,   ACT_WRITE,   8'd0,   8'd0,   32'hFFFE_0000, 1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd255, 8'd255, 32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_REG,  REG_BIAS_U,   ACT_WRITE,   8'd0,   8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_REG,  REG_BIAS_V,   ACT_WRITE,   8'd0,   8'd0,   32'h0001_FFFF, 1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_REG,  REG_BIAS_V,   ACT_WRITE,   8'd0,   8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_REG,  REG_OUT_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0,       1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd127, 8'd127, 32'h0, 1'b1, '{16'd0, 1'b0}},
    '{STEP_REG,  REG_OUT_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd511,     1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd0,   8'd0,   32'h0, 1'b1, '{16'd1, 1'b1}},
    '{STEP_REG,  REG_OUT_SIZE, ACT_WRITE,   8'd0,   8'd0,   32'd16,      1'b0, NO_PX},
    '{STEP_ITEM, REG_SRC_SIZE, ACT_COMPUTE, 8'd240, 8'd200, 32'h0,       1'b0, NO_PX}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_row;
  logic [7:0]  in_col;
  logic [23:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_height;
  logic        out_inside_res;

  // Register copies, changed only while the block is idle.
  logic [8:0]         src_edge = 9'd256;
  logic [8:0]         win_edge = 9'd256;
  logic signed [17:0] shift_u  = '0;
  logic signed [17:0] shift_v  = '0;

  logic [23:0] height_map [MAP_DIM*MAP_DIM];
  bit          map_loaded [MAP_DIM*MAP_DIM];
  pixel_t      heights_due[$];
  preset_t     preset_heights[$];

  int     errors       = 0;
  int     sent         = 0;
  int     results_seen = 0;
  int     idle_pct     = 20;
  int     last_r0      = 0;
  int     last_c0      = 0;
  bit     held_once    = 1'b0;
  longint cycles       = 0;

  clipmap_bilinear_resample_unit u_top (.*);

  always #2 clk = ~clk;

  function automatic longint clamp_edge(logic [8:0] n, int top);
    return (n > top) ? longint'(top) : longint'(n);
  endfunction

  function automatic longint area_limit();
    return (clamp_edge(src_edge, MAP_DIM) - 1) * 256;
  endfunction

  // Q8 source position of an output index along one axis.
  function automatic longint window_pos(logic [7:0] idx, logic signed [17:0] shift);
    return longint'(idx) * 256 + longint'(shift)
           + (clamp_edge(src_edge, MAP_DIM) - 1) * 128
           - (clamp_edge(win_edge, WIN_DIM) - 1) * 128;
  endfunction

  function automatic bit in_area(longint u, longint v);
    return u >= 0 && v >= 0 && u < area_limit() && v < area_limit();
  endfunction

  function automatic longint floor_q8(longint a);
    return (a >= 0) ? a / 256 : -((-a + 255) / 256);
  endfunction

  // An index whose position lands inside the source area, if any does.
  function automatic logic [7:0] pick_index(logic signed [17:0] shift);
    longint base;
    longint lo;
    longint hi;
    base = window_pos(8'd0, shift);
    lo = floor_q8(255 - base);
    hi = floor_q8(area_limit() - 1 - base);
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (lo > hi) return 8'($urandom_range(255, 0));
    return 8'($urandom_range(int'(hi), int'(lo)));
  endfunction

  function automatic logic [23:0] rand_sample();
    return ($urandom_range(9, 0) == 0) ? {24{1'b1}} : 24'($urandom);
  endfunction

  function automatic pixel_t blend_height(logic [7:0] row, logic [7:0] col);
    longint u;
    longint v;
    longint fu;
    longint fv;
    longint d1;
    longint d2;
    longint d3;
    longint d4;
    longint left;
    longint right;
    longint acc;
    int     r0;
    int     c0;
    pixel_t px;
    px = '0;
    u = window_pos(col, shift_u);
    v = window_pos(row, shift_v);
    if (!in_area(u, v)) return px;
    c0 = int'(u / 256);
    r0 = int'(v / 256);
    fu = u % 256;
    fv = v % 256;
    d1 = longint'(height_map[r0*MAP_DIM + c0]);
    d2 = longint'(height_map[r0*MAP_DIM + c0 + 1]);
    d3 = longint'(height_map[(r0 + 1)*MAP_DIM + c0]);
    d4 = longint'(height_map[(r0 + 1)*MAP_DIM + c0 + 1]);
    // Vertical blend first, then horizontal; Q24 before the floor.
    left  = d1 * 256 + (d3 - d1) * fv;
    right = d2 * 256 + (d4 - d2) * fv;
    acc   = left * 256 + (right - left) * fu;
    px.height = 16'(acc >> 24);
    px.hit    = 1'b1;
    return px;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] %s", $time, what);
  endtask

  task automatic offer(action_t act, logic [7:0] row, logic [7:0] col, logic [23:0] smp);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_row    <= row;
    in_col    <= col;
    in_sample <= smp;
    if (act == ACT_WRITE) map_loaded[int'(row)*MAP_DIM + col] = 1'b1;
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Fills any unwritten neighbour of an interpolable pixel before asking for it.
  task automatic offer_pixel(logic [7:0] row, logic [7:0] col, preset_t preset);
    longint u;
    longint v;
    int     r0;
    int     c0;
    u = window_pos(col, shift_u);
    v = window_pos(row, shift_v);
    if (in_area(u, v)) begin
      r0 = int'(v / 256);
      c0 = int'(u / 256);
      last_r0 = r0;
      last_c0 = c0;
      for (int k = 0; k < 4; k++) begin
        if (!map_loaded[(r0 + k/2)*MAP_DIM + c0 + k%2])
          offer(ACT_WRITE, 8'(r0 + k/2), 8'(c0 + k%2), rand_sample());
      end
    end
    preset_heights = {preset_heights, preset};
    offer(ACT_COMPUTE, row, col, 24'($urandom));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      REG_SRC_SIZE: src_edge = value[8:0];
      REG_OUT_SIZE: win_edge = value[8:0];
      REG_BIAS_U:   shift_u  = value[17:0];
      REG_BIAS_V:   shift_v  = value[17:0];
    endcase
    @(posedge clk);
  endtask

  // Writes leave no result behind, so allow a few cycles past the last one.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (heights_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    pixel_t  want;
    pixel_t  due;
    preset_t preset;
    if (rst_n && in_valid && in_ready) begin
      if (action_t'(in_action) == ACT_WRITE) begin
        height_map[int'(in_row)*MAP_DIM + in_col] = in_sample;
      end else begin
        preset = preset_heights.pop_front();
        due = preset.typed ? preset.px : blend_height(in_row, in_col);
        heights_due = {heights_due, due};
      end
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (heights_due.size() == 0) begin
        report_mismatch("result item with nothing due");
      end else begin
        want = heights_due.pop_front();
        if (out_height !== want.height)
          report_mismatch($sformatf("height %0d, expected %0d", out_height, want.height));
        if (out_inside_res !== want.hit)
          report_mismatch($sformatf("inside_res %0b, expected %0b", out_inside_res,
                                    want.hit));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("clipmap_bilinear_resample_unit: mismatch");
      $finish;
    end
  end

  initial begin : receiver
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      // One long hold-off so the queue fills and input is back-pressured.
      if (!held_once && results_seen >= 40) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    step_t step;
    int    phase_end;
    int    pick;
    int    src;
    int    win;
    int    su;
    int    sv;
    rst_n     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    in_action = 1'b0;
    in_row    = '0;
    in_col    = '0;
    in_sample = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      step = PLAN[i];
      if (step.kind == STEP_REG) begin
        settle();
        write_reg(step.idx, step.data);
      end else if (step.act == ACT_WRITE) begin
        offer(ACT_WRITE, step.row, step.col, step.data[23:0]);
      end else begin
        offer_pixel(step.row, step.col, '{step.typed, step.px});
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      su = int'($urandom_range(600, 0)) - 300;
      sv = int'($urandom_range(600, 0)) - 300;
      unique case (phase)
        0: begin src = 2; win = 1; su = 0; sv = 0; end
        1: begin src = 256; win = 256; end
        2: begin src = 511; win = 0; end
        3: begin
          src = $urandom_range(256, 2);
          win = $urandom_range(256, 1);
          su  = int'($urandom_range(4096, 0)) - 2048;
          sv  = int'($urandom_range(4096, 0)) - 2048;
        end
        4: begin
          src = $urandom_range(1, 0);
          win = 511;
          su  = -131072;
          sv  = 131071;
        end
        5: begin
          src = $urandom_range(511, 0);
          win = $urandom_range(511, 0);
          su  = int'($urandom_range(262143, 0)) - 131072;
          sv  = int'($urandom_range(262143, 0)) - 131072;
        end
        default: begin
          src = $urandom_range(256, 2);
          win = $urandom_range(300, 1);
        end
      endcase
      write_reg(REG_SRC_SIZE, 32'(src));
      write_reg(REG_OUT_SIZE, 32'(win));
      write_reg(REG_BIAS_U, 32'(su));
      write_reg(REG_BIAS_V, 32'(sv));
      idle_pct  = PHASE_IDLE[phase];
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        pick = $urandom_range(99, 0);
        if (pick < 65)
          offer_pixel(pick_index(shift_v), pick_index(shift_u), '0);
        else if (pick < 75)
          offer(ACT_WRITE, 8'(last_r0 + $urandom_range(1, 0)),
                8'(last_c0 + $urandom_range(1, 0)), rand_sample());
        else if (pick < 85)
          offer(ACT_WRITE, 8'($urandom), 8'($urandom), rand_sample());
        else
          offer_pixel(8'($urandom), 8'($urandom), '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("clipmap_bilinear_resample_unit: match");
    end else begin
      $display("clipmap_bilinear_resample_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ clipmap_bilinear_resample_unit.f @@
rtl/crs_pkg.sv
rtl/crs_ram.sv
rtl/crs_queue.sv
rtl/crs_front.sv
rtl/crs_back.sv
rtl/clipmap_bilinear_resample_unit.sv
test/tb_top.sv
